@@ rtl/group_reverse_stream_core_defines.svh @@
// Assertion macros for group_reverse_stream_core.
// Uses the clk and rst_n names of the module that includes it.
`ifndef GROUP_REVERSE_STREAM_CORE_DEFINES_SVH
`define GROUP_REVERSE_STREAM_CORE_DEFINES_SVH

// same-cycle implication
`define GRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grs check failed");

// next-cycle implication
`define GRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grs check failed");

`endif

@@ rtl/grs_pkg.sv @@
// Shared types and constants for group_reverse_stream_core.
// No dependencies.
`default_nettype none

package grs_pkg;

    localparam int VALUE_W = 32;
    localparam int CFG_W   = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_list;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_end;
        logic                      group_last;
    } out_item_t;

    typedef struct packed {
        logic last;
        logic eos;
    } rd_meta_t;

    typedef enum logic {
        GRS_IDLE,
        GRS_EMIT
    } grs_state_t;

endpackage

`default_nettype wire

@@ rtl/group_reverse_stream_core.sv @@
// Group reversal stream core: values are stored in a group buffer and read back
// reversed when a group fills, or in arrival order when the end flag closes a short
// group. Each accepted item is one buffer write; a group of n results then reads out
// through the buffer's single read port, one result per cycle when the output is not
// stalled, during which the input is stalled. The buffer needs no clearing after reset.
// Depends on grs_pkg, grs_buffer, grs_ctrl, grs_out, group_reverse_stream_core_defines.svh.
`default_nettype none

`include "group_reverse_stream_core_defines.svh"

module group_reverse_stream_core #(
    parameter int MAX_GROUP  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire grs_pkg::in_item_t           in_data,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      grs_pkg::out_item_t          out_data,
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [grs_pkg::CFG_W-1:0]   cfg_data
);

    import grs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_GROUP);

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    rd_meta_t              rd_meta;
    logic                  rd_credit;
    logic [63:0]           wr_wide;
    logic [63:0]           rd_wide;

    assign cfg_ready = 1'b1;
    assign wr_wide   = {32'd0, in_data.value};
    assign wr_data   = wr_wide[DATA_WIDTH-1:0];
    assign rd_wide   = 64'(rd_data);

    grs_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_eos    (in_data.end_of_list),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rd_credit (rd_credit),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_meta   (rd_meta)
    );

    grs_buffer #(
        .DEPTH (MAX_GROUP),
        .WIDTH (DATA_WIDTH)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    grs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_meta   (rd_meta),
        .rd_value  (rd_wide[VALUE_W-1:0]),
        .rd_credit (rd_credit),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `GRS_ASSERT_NOW(a_no_port_clash, wr_en, !rd_en)
    `GRS_ASSERT_NOW(a_end_on_last, out_valid && out_data.out_end, out_data.group_last)
    `GRS_ASSERT_NEXT(a_resume_after_group, rd_en && rd_meta.last, !in_stall)

endmodule

`default_nettype wire

@@ rtl/grs_buffer.sv @@
// Group buffer: one write port, one read port with registered read data.
// No package dependencies.
`default_nettype none

module grs_buffer #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/grs_ctrl.sv @@
// Control for group_reverse_stream_core: size register, fill count, readout sequencer.
// Depends on grs_pkg.
`default_nettype none

module grs_ctrl #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output      logic                         in_stall,
    input  wire logic                         in_eos,
    input  wire logic                         cfg_we,
    input  wire logic [grs_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         rd_credit,
    output      logic                         wr_en,
    output      logic [$clog2(MAX_GROUP)-1:0] wr_addr,
    output      logic                         rd_en,
    output      logic [$clog2(MAX_GROUP)-1:0] rd_addr,
    output      grs_pkg::rd_meta_t            rd_meta
);

    import grs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_GROUP);
    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int K_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    grs_state_t        state_reg, state_next;
    logic [CFG_W-1:0]  size_reg;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              rev_reg, rev_next;
    logic              eos_reg, eos_next;

    logic [K_W-1:0]    size_ext;
    logic [K_W-1:0]    k_eff;
    logic [CNT_W-1:0]  fill_inc;
    logic              full;
    logic [CNT_W-1:0]  rev_addr;
    logic              last;

    assign size_ext = K_W'(size_reg);
    assign fill_inc = CNT_W'(fill_reg) + CNT_W'(1);
    assign full     = K_W'(fill_inc) >= k_eff;
    assign rev_addr = n_reg - CNT_W'(1) - CNT_W'(idx_reg);
    assign last     = (CNT_W'(idx_reg) + CNT_W'(1)) == n_reg;

    always_comb
    begin
        if (size_ext < K_W'(2))
            k_eff = K_W'(1);
        else if (size_ext > K_W'(MAX_GROUP))
            k_eff = K_W'(MAX_GROUP);
        else
            k_eff = size_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GRS_IDLE;
            size_reg  <= CFG_RESET;
            fill_reg  <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            rev_reg   <= 1'b0;
            eos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            rev_reg   <= rev_next;
            eos_reg   <= eos_next;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        rev_next   = rev_reg;
        eos_next   = eos_reg;
        in_stall   = 1'b1;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (state_reg)
            GRS_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    wr_en = 1'b1;
                    if (full || in_eos)
                    begin
                        state_next = GRS_EMIT;
                        n_next     = fill_inc;
                        rev_next   = full;
                        eos_next   = in_eos;
                        idx_next   = '0;
                        fill_next  = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc[ADDR_W-1:0];
                    end
                end
            end
            GRS_EMIT:
            begin
                if (rd_credit)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + ADDR_W'(1);
                    if (last)
                    begin
                        state_next = GRS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = GRS_IDLE;
            end
        endcase
    end

    assign wr_addr      = fill_reg;
    assign rd_addr      = rev_reg ? rev_addr[ADDR_W-1:0] : idx_reg;
    assign rd_meta.last = last;
    assign rd_meta.eos  = last && eos_reg;

endmodule

`default_nettype wire

@@ rtl/grs_out.sv @@
// Output stage: output register plus skid entry, read-issue credit.
// Depends on grs_pkg.
`default_nettype none

module grs_out (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire grs_pkg::rd_meta_t             rd_meta,
    input  wire logic [grs_pkg::VALUE_W-1:0]   rd_value,
    output      logic                          rd_credit,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      grs_pkg::out_item_t            out_data
);

    import grs_pkg::*;

    logic      pend_reg;
    rd_meta_t  pend_meta_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      pop;
    logic      out_free;
    logic [1:0] occupancy;
    out_item_t arrival;

    assign pop       = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || pop;
    assign occupancy = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(pend_reg) - 2'(pop);
    assign rd_credit = occupancy < 2'd2;

    assign arrival.out_value  = rd_value;
    assign arrival.out_end    = pend_meta_reg.eos;
    assign arrival.group_last = pend_meta_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_en;
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= pend_reg;
                end
                else
                begin
                    out_valid_reg <= pend_reg;
                end
            end
            else if (pend_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_meta_reg <= rd_meta;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (pend_reg)
                begin
                    skid_data_reg <= arrival;
                end
            end
            else if (pend_reg)
            begin
                out_data_reg <= arrival;
            end
        end
        else if (pend_reg)
        begin
            skid_data_reg <= arrival;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
